[src/lcdns_pkg.sv]
`default_nettype none

package lcdns_pkg;

   // attached displays; ids at or above this give an id error on a known call
   localparam int NUM_DISPLAYS = 2;
   localparam int NUM_CSR = 4;
   localparam int CSR_IDX_W = 2;
   localparam int HOLD_W = 17;

   // driver calls
   localparam logic [2:0] FUNC_INIT  = 3'd0;
   localparam logic [2:0] FUNC_CMD   = 3'd1;
   localparam logic [2:0] FUNC_DATA  = 3'd2;
   localparam logic [2:0] FUNC_CLEAR = 3'd3;
   localparam logic [2:0] FUNC_GOTO  = 3'd4;
   localparam logic [2:0] FUNC_SHIFT = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_ON_WAIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_PULSE_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_WAIT      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_WAIT        = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ID_ERR  = 2'd1;
   localparam logic [1:0] STATUS_POS_ERR = 2'd2;

   // controller commands
   localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
   localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_ENTRY_INC = 8'h06;
   localparam logic [7:0] CMD_SHIFT_L   = 8'h18;
   localparam logic [7:0] CMD_SHIFT_R   = 8'h1C;
   localparam logic [7:0] CMD_LINE_ONE  = 8'h80;
   localparam logic [7:0] CMD_LINE_TWO  = 8'hC0;
   localparam logic [7:0] COLUMNS       = 8'd16;

   // job kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_BYTE   = 2'd1;
   localparam logic [1:0] KIND_INIT   = 2'd2;

   // settling wait after the last nibble of a byte
   localparam logic [1:0] TAIL_ZERO = 2'd0;
   localparam logic [1:0] TAIL_CMD  = 2'd1;
   localparam logic [1:0] TAIL_DBL  = 2'd2;
   localparam logic [1:0] TAIL_CLR  = 2'd3;

   typedef struct packed {
      logic [15:0] power_on_wait;
      logic [15:0] enable_pulse_time;
      logic [15:0] command_wait;
      logic [15:0] clear_wait;
   } timing_type;

   typedef struct packed {
      logic [2:0] sel;
      logic [1:0] kind;
      logic       rs;
      logic [7:0] byte_val;
      logic [1:0] tail;
      logic [1:0] status;
   } job_type;

   typedef struct packed {
      logic [2:0]        display_select;
      logic              pins_valid;
      logic              reg_select;
      logic              enable_level;
      logic [3:0]        data_nibble;
      logic [HOLD_W-1:0] hold_time;
      logic [1:0]        status;
      logic              last_frame;
   } frame_type;

endpackage

`default_nettype wire

[src/lcdns_req_if.sv]
`default_nettype none

interface lcdns_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [2:0] display_id;
   logic [7:0] byte_value;
   logic [1:0] line_number;
   logic [7:0] column;
   logic [1:0] shift_direction;

   modport source (
      output valid, func, display_id, byte_value, line_number, column, shift_direction,
      input  ready
   );
   modport sink (
      input  valid, func, display_id, byte_value, line_number, column, shift_direction,
      output ready
   );
endinterface

`default_nettype wire

[src/lcdns_rsp_if.sv]
`default_nettype none

interface lcdns_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  display_select;
   logic        pins_valid;
   logic        reg_select;
   logic        enable_level;
   logic [3:0]  data_nibble;
   logic [16:0] hold_time;
   logic [1:0]  status;
   logic        last_frame;

   modport source (
      output valid, display_select, pins_valid, reg_select, enable_level, data_nibble,
             hold_time, status, last_frame,
      input  ready
   );
   modport sink (
      input  valid, display_select, pins_valid, reg_select, enable_level, data_nibble,
             hold_time, status, last_frame,
      output ready
   );
endinterface

`default_nettype wire

[src/lcdns_csr_if.sv]
`default_nettype none

interface lcdns_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/lcdns_csr.sv]
`default_nettype none

module lcdns_csr (
   input  logic                  clock,
   input  logic                  reset,
   lcdns_csr_if.sink             csr,
   output lcdns_pkg::timing_type timing
);
   import lcdns_pkg::*;

   timing_type timing_ff;

   assign csr.ready = 1'b1;
   assign timing = timing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.power_on_wait     <= 16'd40000;
         timing_ff.enable_pulse_time <= 16'd1000;
         timing_ff.command_wait      <= 16'd50;
         timing_ff.clear_wait        <= 16'd2000;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_POWER_ON_WAIT:     timing_ff.power_on_wait     <= csr.data;
            CSR_ENABLE_PULSE_TIME: timing_ff.enable_pulse_time <= csr.data;
            CSR_COMMAND_WAIT:      timing_ff.command_wait      <= csr.data;
            CSR_CLEAR_WAIT:        timing_ff.clear_wait        <= csr.data;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[src/lcdns_front.sv]
`default_nettype none

module lcdns_front (
   lcdns_req_if.sink          req,
   input  logic               q_ready,
   output logic               q_push,
   output lcdns_pkg::job_type q_job
);
   import lcdns_pkg::*;

   logic id_bad;

   assign req.ready = q_ready;
   assign q_push    = req.valid && q_ready;
   assign id_bad    = ({1'b0, req.display_id} >= 4'(NUM_DISPLAYS));

   always_comb begin
      q_job          = '0;
      q_job.sel      = req.display_id;
      q_job.kind     = KIND_STATUS;
      q_job.status   = STATUS_OK;
      q_job.tail     = TAIL_CMD;
      if (!(req.func inside {[FUNC_INIT:FUNC_SHIFT]})) begin
         q_job.kind = KIND_STATUS;
      end else if (id_bad) begin
         q_job.status = STATUS_ID_ERR;
      end else begin
         case (req.func)
            FUNC_INIT: begin
               q_job.kind = KIND_INIT;
            end
            FUNC_CMD: begin
               q_job.kind     = KIND_BYTE;
               q_job.byte_val = req.byte_value;
            end
            FUNC_DATA: begin
               q_job.kind     = KIND_BYTE;
               q_job.rs       = 1'b1;
               q_job.byte_val = req.byte_value;
               q_job.tail     = TAIL_ZERO;
            end
            FUNC_CLEAR: begin
               q_job.kind     = KIND_BYTE;
               q_job.byte_val = CMD_CLEAR;
               q_job.tail     = TAIL_CLR;
            end
            FUNC_GOTO: begin
               if (req.column >= COLUMNS) begin
                  q_job.status = STATUS_POS_ERR;
               end else if (req.line_number == 2'd0) begin
                  q_job.kind     = KIND_BYTE;
                  q_job.byte_val = CMD_LINE_ONE | {4'd0, req.column[3:0]};
               end else if (req.line_number == 2'd1) begin
                  q_job.kind     = KIND_BYTE;
                  q_job.byte_val = CMD_LINE_TWO | {4'd0, req.column[3:0]};
               end
            end
            FUNC_SHIFT: begin
               if (req.shift_direction == 2'd0) begin
                  q_job.kind     = KIND_BYTE;
                  q_job.byte_val = CMD_SHIFT_L;
               end else if (req.shift_direction == 2'd1) begin
                  q_job.kind     = KIND_BYTE;
                  q_job.byte_val = CMD_SHIFT_R;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[src/lcdns_queue.sv]
`default_nettype none

module lcdns_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lcdns_pkg::job_type push_job,
   output logic               has_room,
   input  logic               pop,
   output logic               not_empty,
   output lcdns_pkg::job_type head_job
);
   import lcdns_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign has_room  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

[src/lcdns_back.sv]
`default_nettype none

module lcdns_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lcdns_pkg::timing_type timing,
   input  logic                  job_valid,
   input  lcdns_pkg::job_type    job,
   output logic                  job_pop,
   lcdns_rsp_if.source           rsp
);
   import lcdns_pkg::*;

   localparam logic [1:0] PRE_POWER   = 2'd0;
   localparam logic [1:0] PRE_LEAD_HI = 2'd1;
   localparam logic [1:0] PRE_LEAD_LO = 2'd2;
   localparam logic [1:0] PRE_DONE    = 2'd3;

   logic       active_ff, active_in;
   job_type    cur_ff, cur_in;
   logic [1:0] pre_ff, pre_in;
   logic [1:0] step_ff, step_in;
   logic [1:0] bcnt_ff, bcnt_in;
   logic       out_vld_ff, out_vld_in;
   frame_type  out_ff, out_in;

   frame_type         frame;
   logic [7:0]        cur_byte;
   logic [1:0]        cur_tail;
   logic [HOLD_W-1:0] tail_hold;
   logic              advance;
   logic              job_done;

   // init byte run after the lead nibble
   function automatic logic [7:0] init_cmd(input logic [1:0] idx);
      case (idx)
         2'd0:    init_cmd = CMD_FUNC_SET;
         2'd1:    init_cmd = CMD_DISP_ON;
         2'd2:    init_cmd = CMD_CLEAR;
         default: init_cmd = CMD_ENTRY_INC;
      endcase
   endfunction

   function automatic logic [1:0] init_tail(input logic [1:0] idx);
      case (idx)
         2'd0, 2'd1: init_tail = TAIL_DBL;
         2'd2:       init_tail = TAIL_CLR;
         default:    init_tail = TAIL_CMD;
      endcase
   endfunction

   assign cur_byte = (cur_ff.kind == KIND_INIT) ? init_cmd(bcnt_ff) : cur_ff.byte_val;
   assign cur_tail = (cur_ff.kind == KIND_INIT) ? init_tail(bcnt_ff) : cur_ff.tail;

   always_comb begin
      case (cur_tail)
         TAIL_ZERO: tail_hold = '0;
         TAIL_CMD:  tail_hold = {1'b0, timing.command_wait};
         TAIL_DBL:  tail_hold = {timing.command_wait, 1'b0};
         TAIL_CLR:  tail_hold = {1'b0, timing.command_wait} + {1'b0, timing.clear_wait};
         default:   tail_hold = '0;
      endcase
   end

   always_comb begin
      frame                = '0;
      frame.display_select = cur_ff.sel;
      if (cur_ff.kind == KIND_STATUS) begin
         frame.status     = cur_ff.status;
         frame.last_frame = 1'b1;
      end else begin
         frame.pins_valid = 1'b1;
         frame.reg_select = cur_ff.rs;
         case (pre_ff)
            PRE_POWER: begin
               frame.hold_time = {1'b0, timing.power_on_wait};
            end
            PRE_LEAD_HI: begin
               frame.enable_level = 1'b1;
               frame.data_nibble  = CMD_FUNC_SET[7:4];
               frame.hold_time    = {1'b0, timing.enable_pulse_time};
            end
            PRE_LEAD_LO: begin
               frame.data_nibble = CMD_FUNC_SET[7:4];
            end
            default: begin
               frame.enable_level = !step_ff[0];
               frame.data_nibble  = step_ff[1] ? cur_byte[3:0] : cur_byte[7:4];
               if (!step_ff[0]) begin
                  frame.hold_time = {1'b0, timing.enable_pulse_time};
               end else if (step_ff[1]) begin
                  frame.hold_time = tail_hold;
               end
               frame.last_frame = (step_ff == 2'd3) &&
                                  ((cur_ff.kind != KIND_INIT) || (bcnt_ff == 2'd3));
            end
         endcase
      end
   end

   // output register loads from an active call whenever it is empty or being drained
   assign advance  = active_ff && (!out_vld_ff || rsp.ready);
   assign job_done = advance && frame.last_frame;
   assign job_pop  = job_valid && (!active_ff || job_done);

   always_comb begin
      active_in = active_ff;
      cur_in    = cur_ff;
      pre_in    = pre_ff;
      step_in   = step_ff;
      bcnt_in   = bcnt_ff;
      if (advance) begin
         if (pre_ff != PRE_DONE) begin
            pre_in = pre_ff + 2'd1;
         end else begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               bcnt_in = bcnt_ff + 2'd1;
            end
         end
         if (job_done) begin
            active_in = 1'b0;
         end
      end
      if (job_pop) begin
         active_in = 1'b1;
         cur_in    = job;
         pre_in    = (job.kind == KIND_INIT) ? PRE_POWER : PRE_DONE;
         step_in   = 2'd0;
         bcnt_in   = 2'd0;
      end
      out_vld_in = advance ? 1'b1 : (out_vld_ff && !rsp.ready);
      out_in     = advance ? frame : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pre_ff     <= PRE_DONE;
         step_ff    <= 2'd0;
         bcnt_ff    <= 2'd0;
         out_vld_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         pre_ff     <= pre_in;
         step_ff    <= step_in;
         bcnt_ff    <= bcnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp.valid          = out_vld_ff;
   assign rsp.display_select = out_ff.display_select;
   assign rsp.pins_valid     = out_ff.pins_valid;
   assign rsp.reg_select     = out_ff.reg_select;
   assign rsp.enable_level   = out_ff.enable_level;
   assign rsp.data_nibble    = out_ff.data_nibble;
   assign rsp.hold_time      = out_ff.hold_time;
   assign rsp.status         = out_ff.status;
   assign rsp.last_frame     = out_ff.last_frame;

endmodule

`default_nettype wire

[src/char_lcd_nibble_sequencer_top.sv]
`default_nettype none

// Four-bit character LCD sequencer: each word on req_if is one driver call (init, command,
// data char, clear, goto, shift) and comes back on rsp_if as a run of pin frames, one frame
// per word, high nibble first with an enable-high and an enable-low frame per nibble, the
// last frame of a run flagged by last_frame. A command, character, clear, goto or shift
// gives 4 frames, init gives 19, and a bad display id, bad column, unknown line, unknown
// shift direction or unknown call gives a single status-only frame. The back-end sequencer
// emits one frame per cycle while rsp_if is ready; the next queued call is loaded with the
// last frame of the one before. A call taken by an idle block goes from the queue into the
// sequencer and then into the output register before its first frame is valid on rsp_if. A
// two-word queue between the call decoder and the sequencer lets new calls be taken while
// frames are still going out. Timing registers on csr_if (index 0 power-on wait, 1 enable
// pulse, 2 command wait, 3 clear wait, all in microseconds) are to be written only while the
// block is idle, then taking effect on the next call; the block itself does not enforce this.

module char_lcd_nibble_sequencer_top (
   input  logic      clock,
   input  logic      reset,
   lcdns_req_if.sink   req_if,
   lcdns_rsp_if.source rsp_if,
   lcdns_csr_if.sink   csr_if
);
   import lcdns_pkg::*;

   timing_type timing;     // live timing registers
   logic       q_ready;    // queue can take a decoded call
   logic       q_push;
   job_type    q_push_job; // decoded call
   logic       q_valid;
   logic       q_pop;
   job_type    q_head_job;

   // timing register file
   lcdns_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr_if),
      .timing (timing)
   );

   // call decoder: picks frame-run kind, command byte and settling wait
   lcdns_front u_front (
      .req     (req_if),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_job   (q_push_job)
   );

   // decoupling queue between decoder and sequencer
   lcdns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .has_room  (q_ready),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_job  (q_head_job)
   );

   // frame sequencer with registered output
   lcdns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .timing    (timing),
      .job_valid (q_valid),
      .job       (q_head_job),
      .job_pop   (q_pop),
      .rsp       (rsp_if)
   );

endmodule

`default_nettype wire

[tb/char_lcd_nibble_sequencer_top_test.sv]
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_top_test;
   import lcdns_pkg::*;

   // call codes that the package leaves unnamed
   localparam logic [2:0] FUNC_RSVD6 = 3'd6;
   localparam logic [2:0] FUNC_RSVD7 = 3'd7;
   localparam logic [1:0] LINE_FIRST = 2'd0;
   localparam logic [1:0] LINE_SECOND = 2'd1;
   localparam logic [1:0] LINE_BAD2 = 2'd2;
   localparam logic [1:0] LINE_BAD3 = 2'd3;
   localparam logic [1:0] DIR_LEFT = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_BAD2 = 2'd2;
   localparam logic [1:0] DIR_BAD3 = 2'd3;

   // percent of cycles in which each side holds back
   localparam int IDLE_PCT = 7;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [2:0] func;
      logic [2:0] display_id;
      logic [7:0] byte_value;
      logic [1:0] line_number;
      logic [7:0] column;
      logic [1:0] shift_direction;
   } lcd_call_type;

   logic clock = 1'b0;
   logic reset;
   logic steady;

   lcdns_req_if req_if();
   lcdns_rsp_if rsp_if();
   lcdns_csr_if csr_if();

   char_lcd_nibble_sequencer_top DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // calls waiting for the bus, frames waiting for the block
   lcd_call_type pending_calls[$];
   lcd_call_type call_on_bus;
   frame_type expected_frames[$];
   frame_type frame_run[$];
   logic [2:0] run_sel;

   // our own copy of the timing registers
   timing_type timing;

   int unsigned calls_taken;
   int unsigned frames_checked;
   int unsigned mismatches;
   int unsigned setups;

   // ---------------------------------------------------------------
   // frame predictor
   // ---------------------------------------------------------------

   function automatic void add_frame(logic pv, logic rs, logic en, logic [3:0] nib,
                                     logic [HOLD_W-1:0] hold, logic [1:0] st);
      frame_type f;
      f.display_select = run_sel;
      f.pins_valid = pv;
      f.reg_select = rs;
      f.enable_level = en;
      f.data_nibble = nib;
      f.hold_time = hold;
      f.status = st;
      f.last_frame = 1'b0;
      frame_run.push_back(f);
   endfunction

   // enable-high frame, then enable-low frame carrying the settling wait
   function automatic void add_nibble(logic rs, logic [3:0] nib, logic [HOLD_W-1:0] tail);
      add_frame(1'b1, rs, 1'b1, nib, {1'b0, timing.enable_pulse_time}, STATUS_OK);
      add_frame(1'b1, rs, 1'b0, nib, tail, STATUS_OK);
   endfunction

   // high nibble first, only the low nibble carries the tail
   function automatic void add_byte(logic rs, logic [7:0] b, logic [HOLD_W-1:0] tail);
      add_nibble(rs, b[7:4], '0);
      add_nibble(rs, b[3:0], tail);
   endfunction

   function automatic void predict_frames(lcd_call_type c);
      logic [HOLD_W-1:0] cmd_hold;
      logic [HOLD_W-1:0] dbl_hold;
      logic [HOLD_W-1:0] clr_hold;
      frame_type f;
      cmd_hold = {1'b0, timing.command_wait};
      dbl_hold = {timing.command_wait, 1'b0};
      clr_hold = {1'b0, timing.command_wait} + {1'b0, timing.clear_wait};
      frame_run.delete();
      run_sel = c.display_id;
      // unknown call wins over a bad id
      if (c.func > FUNC_SHIFT) begin
         add_frame(1'b0, 1'b0, 1'b0, '0, '0, STATUS_OK);
      end else if (c.display_id >= NUM_DISPLAYS) begin
         add_frame(1'b0, 1'b0, 1'b0, '0, '0, STATUS_ID_ERR);
      end else begin
         case (c.func)
            FUNC_INIT: begin
               // power-on frame with all pins low, then the lone 4-bit switch nibble
               add_frame(1'b1, 1'b0, 1'b0, '0, {1'b0, timing.power_on_wait}, STATUS_OK);
               add_nibble(1'b0, CMD_FUNC_SET[7:4], '0);
               add_byte(1'b0, CMD_FUNC_SET, dbl_hold);
               add_byte(1'b0, CMD_DISP_ON, dbl_hold);
               add_byte(1'b0, CMD_CLEAR, clr_hold);
               add_byte(1'b0, CMD_ENTRY_INC, cmd_hold);
            end
            FUNC_CMD: add_byte(1'b0, c.byte_value, cmd_hold);
            FUNC_DATA: add_byte(1'b1, c.byte_value, '0);
            FUNC_CLEAR: add_byte(1'b0, CMD_CLEAR, clr_hold);
            FUNC_GOTO: begin
               if (c.column >= COLUMNS)
                  add_frame(1'b0, 1'b0, 1'b0, '0, '0, STATUS_POS_ERR);
               else if (c.line_number == LINE_FIRST)
                  add_byte(1'b0, CMD_LINE_ONE + c.column, cmd_hold);
               else if (c.line_number == LINE_SECOND)
                  add_byte(1'b0, CMD_LINE_TWO + c.column, cmd_hold);
               else
                  add_frame(1'b0, 1'b0, 1'b0, '0, '0, STATUS_OK);
            end
            default: begin
               if (c.shift_direction == DIR_LEFT)
                  add_byte(1'b0, CMD_SHIFT_L, cmd_hold);
               else if (c.shift_direction == DIR_RIGHT)
                  add_byte(1'b0, CMD_SHIFT_R, cmd_hold);
               else
                  add_frame(1'b0, 1'b0, 1'b0, '0, '0, STATUS_OK);
            end
         endcase
      end
      f = frame_run.pop_back();
      f.last_frame = 1'b1;
      frame_run.push_back(f);
      foreach (frame_run[i]) expected_frames.push_back(frame_run[i]);
   endfunction

   function automatic string frame_text(frame_type f);
      return $sformatf("sel=%0d pv=%0b rs=%0b en=%0b nib=%h hold=%0d st=%0d last=%0b",
                       f.display_select, f.pins_valid, f.reg_select, f.enable_level,
                       f.data_nibble, f.hold_time, f.status, f.last_frame);
   endfunction

   // ---------------------------------------------------------------
   // call driver: one word per accepted call
   // ---------------------------------------------------------------

   always @(posedge clock) begin : drive_calls
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         // the word on the bus was taken at this edge
         if (req_if.valid && req_if.ready) begin
            predict_frames(call_on_bus);
            calls_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_calls.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               call_on_bus = pending_calls.pop_front();
               req_if.valid <= 1'b1;
               req_if.func <= call_on_bus.func;
               req_if.display_id <= call_on_bus.display_id;
               req_if.byte_value <= call_on_bus.byte_value;
               req_if.line_number <= call_on_bus.line_number;
               req_if.column <= call_on_bus.column;
               req_if.shift_direction <= call_on_bus.shift_direction;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // frame monitor: each frame word against the oldest expected one
   // ---------------------------------------------------------------

   always @(posedge clock) begin : watch_frames
      frame_type got;
      frame_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.display_select = rsp_if.display_select;
            got.pins_valid = rsp_if.pins_valid;
            got.reg_select = rsp_if.reg_select;
            got.enable_level = rsp_if.enable_level;
            got.data_nibble = rsp_if.data_nibble;
            got.hold_time = rsp_if.hold_time;
            got.status = rsp_if.status;
            got.last_frame = rsp_if.last_frame;
            if (expected_frames.size() == 0) begin
               // frame with nothing predicted
               if (mismatches < MAX_REPORTS)
                  $display("%0t: unexpected frame: %s", $realtime, frame_text(got));
               mismatches++;
            end else begin
               want = expected_frames.pop_front();
               if (got !== want) begin
                  if (mismatches < MAX_REPORTS)
                     $display("%0t: frame %0d mismatch\n   expected %s\n   actual   %s",
                              $realtime, frames_checked, frame_text(want), frame_text(got));
                  mismatches++;
               end
               frames_checked++;
            end
         end
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   function automatic lcd_call_type call_of(logic [2:0] func, logic [2:0] id, logic [7:0] b,
                                            logic [1:0] ln, logic [7:0] col, logic [1:0] dir);
      lcd_call_type c;
      c.func = func;
      c.display_id = id;
      c.byte_value = b;
      c.line_number = ln;
      c.column = col;
      c.shift_direction = dir;
      return c;
   endfunction

   // mostly well-formed calls on attached displays, some noise
   function automatic lcd_call_type random_call();
      lcd_call_type c;
      c.func = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      c.display_id = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, NUM_DISPLAYS - 1))
                                                  : 3'($urandom_range(NUM_DISPLAYS, 7));
      c.byte_value = 8'($urandom_range(0, 255));
      c.line_number = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1))
                                                   : 2'($urandom_range(2, 3));
      c.column = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(16, 255));
      c.shift_direction = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1))
                                                       : 2'($urandom_range(2, 3));
      return c;
   endfunction

   task automatic queue_random(int count);
      repeat (count) pending_calls.push_back(random_call());
   endtask

   // block is idle once every call is on its way and every frame is back
   task automatic drain();
      while (!(pending_calls.size() == 0 && !req_if.valid && expected_frames.size() == 0))
         @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_POWER_ON_WAIT: timing.power_on_wait = value;
         CSR_ENABLE_PULSE_TIME: timing.enable_pulse_time = value;
         CSR_COMMAND_WAIT: timing.command_wait = value;
         default: timing.clear_wait = value;
      endcase
   endtask

   task automatic program_timing(logic [15:0] pow, logic [15:0] pulse, logic [15:0] cmd,
                                 logic [15:0] clr);
      write_csr(CSR_POWER_ON_WAIT, pow);
      write_csr(CSR_ENABLE_PULSE_TIME, pulse);
      write_csr(CSR_COMMAND_WAIT, cmd);
      write_csr(CSR_CLEAR_WAIT, clr);
      setups++;
   endtask

   initial begin : stimulus
      // every input known from time zero
      reset = 1'b1;
      steady = 1'b0;
      req_if.valid = 1'b0;
      req_if.func = FUNC_INIT;
      req_if.display_id = '0;
      req_if.byte_value = '0;
      req_if.line_number = '0;
      req_if.column = '0;
      req_if.shift_direction = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_POWER_ON_WAIT;
      csr_if.data = '0;
      calls_taken = 0;
      frames_checked = 0;
      mismatches = 0;
      setups = 1;
      // register values after reset
      timing.power_on_wait = 16'd40000;
      timing.enable_pulse_time = 16'd1000;
      timing.command_wait = 16'd50;
      timing.clear_wait = 16'd2000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed calls at reset timing
      pending_calls.push_back(call_of(FUNC_INIT, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_CMD, 3'd1, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_CMD, 3'd0, 8'hFF, LINE_SECOND, 8'd255, DIR_BAD3));
      pending_calls.push_back(call_of(FUNC_DATA, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_DATA, 3'd1, 8'hFF, LINE_BAD3, 8'd255, DIR_BAD3));
      pending_calls.push_back(call_of(FUNC_CLEAR, 3'd1, 8'hA5, LINE_FIRST, 8'd0, DIR_LEFT));
      // goto: both lines at both column ends, column errors, unknown lines
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd1, 8'h00, LINE_SECOND, 8'd15, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd0, 8'h00, LINE_FIRST, 8'd15, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd1, 8'h00, LINE_SECOND, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd0, 8'h00, LINE_FIRST, 8'd16, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd1, 8'h00, LINE_BAD2, 8'd255, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd0, 8'h00, LINE_BAD2, 8'd5, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd1, 8'h00, LINE_BAD3, 8'd9, DIR_LEFT));
      // bad id beats a column error
      pending_calls.push_back(call_of(FUNC_GOTO, 3'd7, 8'h00, LINE_FIRST, 8'd200, DIR_LEFT));
      // shifts, both known directions and both unknown ones
      pending_calls.push_back(call_of(FUNC_SHIFT, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_SHIFT, 3'd1, 8'h00, LINE_FIRST, 8'd0, DIR_RIGHT));
      pending_calls.push_back(call_of(FUNC_SHIFT, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_BAD2));
      pending_calls.push_back(call_of(FUNC_SHIFT, 3'd1, 8'h00, LINE_FIRST, 8'd0, DIR_BAD3));
      // display id errors: first missing id and the top id
      pending_calls.push_back(call_of(FUNC_DATA, 3'd2, 8'h41, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_INIT, 3'd7, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      // unknown calls, even on a missing display
      pending_calls.push_back(call_of(FUNC_RSVD6, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_RSVD7, 3'd7, 8'hFF, LINE_BAD3, 8'd255, DIR_BAD3));
      drain();

      // all waits zero
      program_timing('0, '0, '0, '0);
      pending_calls.push_back(call_of(FUNC_INIT, 3'd1, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      queue_random(25);
      drain();

      // all waits at the top, doubled and summed holds reach the 17th bit
      program_timing('1, '1, '1, '1);
      pending_calls.push_back(call_of(FUNC_INIT, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      pending_calls.push_back(call_of(FUNC_CLEAR, 3'd0, 8'h00, LINE_FIRST, 8'd0, DIR_LEFT));
      queue_random(25);
      drain();

      // random timing, back to back words with no idling on either side
      program_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      steady = 1'b1;
      queue_random(30);
      drain();
      steady = 1'b0;

      // random timing again with idling
      program_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      queue_random(25);
      drain();

      // let any stray frame show up
      repeat (40) @(posedge clock);

      $display("covered %0d lcd calls and %0d pin frames over %0d timing setups",
               calls_taken, frames_checked, setups);
      $display("%0d frame mismatches, %0d frames still outstanding",
               mismatches, expected_frames.size());
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #400000;
      $display("FAIL");
      $finish;
   end

endmodule
